/* hdl/cvcc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CV/CC duty controller package
// Widths, fixed constants, register indexes and shared types of the
// constant-voltage / constant-current PI duty controller.
// ----------------------------------------------------------------------------
package cvcc_pkg;

  localparam int CODE_W      = 16;
  localparam int SCALE_W     = 16;
  localparam int GAIN_W      = 24;
  localparam int SETV_W      = 15;
  localparam int SETI_W      = 13;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int DUTY_W      = 11;
  localparam int MAG_W       = 18;
  localparam int ERR_W       = 20;
  localparam int INTEG_W     = 15;
  localparam int ACC_W       = 21;
  localparam int PROD_W      = 45;
  localparam int SUM_W       = 46;
  localparam int TERM_W      = 22;
  localparam int DSUM_W      = 23;

  localparam int SCALE_SHIFT = 14;
  localparam int GAIN_SHIFT  = 24;
  localparam int GAIN_BIAS   = (1 << GAIN_SHIFT) - 1;
  localparam int HYST_MA     = 50;
  localparam int INTEG_LIMIT = 10000;
  localparam int DUTY_RESET  = 300;

  localparam int RST_SET_VOLTAGE = 1200;
  localparam int RST_SET_CURRENT = 150;
  localparam int RST_V_SCALE     = 4869;
  localparam int RST_I_SCALE     = 3052;
  localparam int RST_KP_VOLTAGE  = 14260;
  localparam int RST_KI_VOLTAGE  = 1342;
  localparam int RST_KP_CURRENT  = 335544;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_VOLTAGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_CURRENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_V_SCALE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_I_SCALE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_VOLTAGE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KI_VOLTAGE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_KP_CURRENT  = 3'd6;

  typedef logic        [MAG_W-1:0]   mag_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic signed [INTEG_W-1:0] integ_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [TERM_W-1:0]  term_t;
  typedef logic signed [DSUM_W-1:0]  dsum_t;

endpackage
`default_nettype wire

/* hdl/cvcc_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CV/CC shared multiplier
// Registered multiplier of an unsigned gain or scale by a signed operand,
// shared by every product of one control tick.
// ----------------------------------------------------------------------------
module cvcc_mul
  import cvcc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [GAIN_W-1:0] a,
  input  wire err_t              b,
  output prod_t                  p_r
);

  logic signed [GAIN_W:0] a_s;
  prod_t                  a_x;
  prod_t                  b_x;
  prod_t                  p_nxt;

  assign a_s   = $signed({1'b0, a});
  assign a_x   = prod_t'(a_s);
  assign b_x   = prod_t'(b);
  assign p_nxt = a_x * b_x;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule
`default_nettype wire

/* hdl/cv_cc_pi_duty_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CV/CC PI duty controller
// Buck converter regulator that turns filtered voltage and current readings
// into a clamped PWM compare value, in voltage (PI) or current-limit (P) mode.
// ----------------------------------------------------------------------------
// Each accepted tick is worked through one shared registered multiplier under
// a small sequencer: two scaling products, a mode select, the proportional
// product and the integral product, then a sum, a truncation and the duty
// update. After its transfer a tick passes the states MV, MA, SEL, PROP, INT,
// SUM, TRUNC and OUT, and its result is loaded into the output register in
// OUT; the sequencer then returns to IDLE, where it takes the next transfer.
// The input stalls while a tick is in work. The result is held in the final
// step until the previous result has been transferred.
module cv_cc_pi_duty_controller
  import cvcc_pkg::*;
#(
  parameter int DUTY_MAX = 1450
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CODE_W-1:0]     in_voltage_code,
  input  wire logic [CODE_W-1:0]     in_current_code,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [DUTY_W-1:0]          out_duty,
  output logic                       out_limit_active
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MV    = 4'd1;
  localparam logic [3:0] ST_MA    = 4'd2;
  localparam logic [3:0] ST_SEL   = 4'd3;
  localparam logic [3:0] ST_PROP  = 4'd4;
  localparam logic [3:0] ST_INT   = 4'd5;
  localparam logic [3:0] ST_SUM   = 4'd6;
  localparam logic [3:0] ST_TRUNC = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  logic [3:0]         state_r, state_nxt;
  logic [SETV_W-1:0]  setv_r;
  logic [SETI_W-1:0]  seti_r;
  logic [SCALE_W-1:0] vscale_r;
  logic [SCALE_W-1:0] iscale_r;
  logic [GAIN_W-1:0]  kpv_r;
  logic [GAIN_W-1:0]  kiv_r;
  logic [GAIN_W-1:0]  kpc_r;

  logic [DUTY_W-1:0]  duty_r, duty_nxt;
  integ_t             integ_r, integ_nxt;
  logic               limit_r, limit_nxt;
  logic               curr_r, curr_nxt;

  logic [CODE_W-1:0]  vcode_r;
  logic [CODE_W-1:0]  icode_r;
  mag_t               mv_r;
  err_t               err_r, err_nxt;
  sum_t               sum_r, sum_nxt;
  term_t              term_r;

  logic               out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0]  out_duty_r;
  logic               out_limit_r;

  logic [GAIN_W-1:0]  mul_a;
  err_t               mul_b;
  prod_t              prod;

  logic               in_xfer;
  logic               out_free;
  mag_t               ma;
  logic               ma_gt;
  logic [MAG_W:0]     ma_hyst;
  logic               ma_below;
  logic               curr_tick;
  err_t               err_i;
  err_t               err_v;
  acc_t               acc;
  acc_t               acc_cl;
  sum_t               rounded;
  dsum_t              dnext;
  logic [DUTY_W-1:0]  duty_sat;

  assign in_stall         = (state_r != ST_IDLE);
  assign in_xfer          = in_valid && !in_stall;
  assign out_free         = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_duty         = out_duty_r;
  assign out_limit_active = out_limit_r;

  cvcc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MV: begin
        mul_a = GAIN_W'(vscale_r);
        mul_b = err_t'(vcode_r);
      end
      ST_MA: begin
        mul_a = GAIN_W'(iscale_r);
        mul_b = err_t'(icode_r);
      end
      ST_PROP: begin
        mul_a = curr_r ? kpc_r : kpv_r;
        mul_b = err_r;
      end
      ST_INT: begin
        mul_a = curr_r ? '0 : kiv_r;
        mul_b = err_t'(integ_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    ma        = prod[SCALE_SHIFT+MAG_W-1:SCALE_SHIFT];
    ma_gt     = ma > MAG_W'(seti_r);
    ma_hyst   = (MAG_W+1)'(ma) + (MAG_W+1)'(HYST_MA);
    ma_below  = ma_hyst < (MAG_W+1)'(seti_r);
    curr_tick = ma_gt || limit_r;
    err_i     = err_t'(seti_r) - err_t'(ma);
    err_v     = err_t'(setv_r) - err_t'(mv_r);
    acc       = acc_t'(integ_r) + acc_t'(err_v);
    if (acc > acc_t'(INTEG_LIMIT)) begin
      acc_cl = acc_t'(INTEG_LIMIT);
    end else if (acc < acc_t'(-INTEG_LIMIT)) begin
      acc_cl = acc_t'(-INTEG_LIMIT);
    end else begin
      acc_cl = acc;
    end
    rounded = sum_r + (sum_r[SUM_W-1] ? sum_t'(GAIN_BIAS) : sum_t'(0));
    dnext   = dsum_t'(duty_r) + dsum_t'(term_r);
    if (dnext[DSUM_W-1]) begin
      duty_sat = '0;
    end else if (dnext > dsum_t'(DUTY_MAX)) begin
      duty_sat = DUTY_W'(DUTY_MAX);
    end else begin
      duty_sat = dnext[DUTY_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    duty_nxt      = duty_r;
    integ_nxt     = integ_r;
    limit_nxt     = limit_r;
    curr_nxt      = curr_r;
    err_nxt       = err_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_MV;
        end
      end
      ST_MV: begin
        state_nxt = ST_MA;
      end
      ST_MA: begin
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        curr_nxt  = curr_tick;
        limit_nxt = curr_tick && !ma_below;
        if (curr_tick) begin
          err_nxt = err_i;
        end else begin
          err_nxt   = err_v;
          integ_nxt = integ_t'(acc_cl);
        end
        state_nxt = ST_PROP;
      end
      ST_PROP: begin
        state_nxt = ST_INT;
      end
      ST_INT: begin
        sum_nxt   = sum_t'(prod);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        sum_nxt   = sum_r + sum_t'(prod);
        state_nxt = ST_TRUNC;
      end
      ST_TRUNC: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          duty_nxt      = duty_sat;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      duty_r      <= DUTY_W'(DUTY_RESET);
      integ_r     <= '0;
      limit_r     <= 1'b0;
      curr_r      <= 1'b0;
      setv_r      <= SETV_W'(RST_SET_VOLTAGE);
      seti_r      <= SETI_W'(RST_SET_CURRENT);
      vscale_r    <= SCALE_W'(RST_V_SCALE);
      iscale_r    <= SCALE_W'(RST_I_SCALE);
      kpv_r       <= GAIN_W'(RST_KP_VOLTAGE);
      kiv_r       <= GAIN_W'(RST_KI_VOLTAGE);
      kpc_r       <= GAIN_W'(RST_KP_CURRENT);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      duty_r      <= duty_nxt;
      integ_r     <= integ_nxt;
      limit_r     <= limit_nxt;
      curr_r      <= curr_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_VOLTAGE: setv_r   <= cfg_data[SETV_W-1:0];
          CFG_SET_CURRENT: seti_r   <= cfg_data[SETI_W-1:0];
          CFG_V_SCALE:     vscale_r <= cfg_data[SCALE_W-1:0];
          CFG_I_SCALE:     iscale_r <= cfg_data[SCALE_W-1:0];
          CFG_KP_VOLTAGE:  kpv_r    <= cfg_data[GAIN_W-1:0];
          CFG_KI_VOLTAGE:  kiv_r    <= cfg_data[GAIN_W-1:0];
          CFG_KP_CURRENT:  kpc_r    <= cfg_data[GAIN_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      vcode_r <= in_voltage_code;
      icode_r <= in_current_code;
    end
    if (state_r == ST_MA) begin
      mv_r <= prod[SCALE_SHIFT+MAG_W-1:SCALE_SHIFT];
    end
    if (state_r == ST_TRUNC) begin
      term_r <= term_t'(rounded >>> GAIN_SHIFT);
    end
    if (state_r == ST_OUT && out_free) begin
      out_duty_r  <= duty_sat;
      out_limit_r <= limit_r;
    end
    err_r <= err_nxt;
    sum_r <= sum_nxt;
  end

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_duty_r <= DUTY_W'(DUTY_MAX)))
    else $error("output duty above the maximum");

  a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
    (integ_r <= integ_t'(INTEG_LIMIT)) && (integ_r >= integ_t'(-INTEG_LIMIT)))
    else $error("voltage integral outside its clamp");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_MV))
    else $error("input transfer did not start the sequence");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded into the output register");

endmodule
`default_nettype wire
